FILE: rtl/core/dtgd_pkg.sv
// Package for the double-tap gesture detector: field widths, register
// indexes, reset values of the window registers and reject codes.
// No dependencies.
package dtgd_pkg;

  localparam int unsigned IdW    = 29;
  localparam int unsigned LenW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = IdW;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_ID  = 3'd0,
    CFG_PRESS_MIN = 3'd1,
    CFG_PRESS_MAX = 3'd2,
    CFG_GAP_MIN   = 3'd3,
    CFG_GAP_MAX   = 3'd4
  } cfg_idx_e;

  localparam logic [IdW-1:0]  MatchIdRst  = '0;
  localparam logic [DurW-1:0] PressMinRst = 16'd40;
  localparam logic [DurW-1:0] PressMaxRst = 16'd500;
  localparam logic [DurW-1:0] GapMinRst   = 16'd120;
  localparam logic [DurW-1:0] GapMaxRst   = 16'd900;

  localparam logic [DurW-1:0] DurSat = 16'hFFFF;

  // Reject codes reported with every result
  typedef enum logic [2:0] {
    REJ_NONE   = 3'd0,
    REJ_AUTO   = 3'd1,
    REJ_PSHORT = 3'd2,
    REJ_PLONG  = 3'd3,
    REJ_GSHORT = 3'd4,
    REJ_GLONG  = 3'd5
  } reject_e;

  // Saturate a wrapped 32-bit difference to 16 bits
  function automatic logic [DurW-1:0] sat_dur(input logic [TimeW-1:0] v);
    sat_dur = (|v[TimeW-1:DurW]) ? DurSat : v[DurW-1:0];
  endfunction

endpackage

FILE: rtl/core/dtgd_if.sv
// Stream interfaces of the double-tap gesture detector: frame beats in,
// result beats out. Depends on dtgd_pkg.
interface dtgd_frame_if;
  logic                      valid;
  logic                      ready;
  logic [dtgd_pkg::IdW-1:0]   frame_id;
  logic [dtgd_pkg::LenW-1:0]  frame_len;
  logic [dtgd_pkg::ByteW-1:0] status_byte;
  logic [dtgd_pkg::ByteW-1:0] button_byte;
  logic [dtgd_pkg::TimeW-1:0] now_ms;

  modport source (output valid, frame_id, frame_len, status_byte, button_byte, now_ms,
                  input ready);
  modport sink (input valid, frame_id, frame_len, status_byte, button_byte, now_ms,
                output ready);
endinterface

interface dtgd_result_if;
  logic                       valid;
  logic                       ready;
  logic                       gesture;
  logic                       accepted;
  logic [dtgd_pkg::DurW-1:0]  tap_count;
  dtgd_pkg::reject_e          reject_code;
  logic [dtgd_pkg::DurW-1:0]  press_length;
  logic [dtgd_pkg::DurW-1:0]  gap_length;
  logic [dtgd_pkg::TimeW-1:0] min_frame_gap;
  logic                       driver_here;
  logic                       driver_known;
  logic [dtgd_pkg::TimeW-1:0] driver_time;
  logic [dtgd_pkg::ByteW-1:0] rise_byte;
  logic [dtgd_pkg::TimeW-1:0] gesture_time;

  modport source (output valid, gesture, accepted, tap_count, reject_code, press_length,
                         gap_length, min_frame_gap, driver_here, driver_known,
                         driver_time, rise_byte, gesture_time,
                  input ready);
  modport sink (input valid, gesture, accepted, tap_count, reject_code, press_length,
                      gap_length, min_frame_gap, driver_here, driver_known,
                      driver_time, rise_byte, gesture_time,
                output ready);
endinterface

FILE: rtl/core/double_tap_gesture_detector.sv
// Top level of the double-tap gesture detector: frame filter, tap timing,
// window checks and gesture counter. Depends on dtgd_pkg and dtgd_if.
//
//   channel   dir   handshake       carries
//   -------   ---   -------------   -------------------------------------------
//   in_if     in    valid/ready     one received bus frame per beat
//   out_if    out   valid/ready     one status result per frame beat
//   cfg_*     in    cfg_we_i only   window registers and frame identifier
//
// A frame beat lands in the input register, and its result then moves to
// the output register; one beat per cycle is sustained while out_if does not
// stall. The tap state updates when the frame moves from the input
// register to the output register, so back-to-back frames see each other.
// A stall on out_if holds both registers; in_if.ready drops only when the
// input register is full and cannot advance. Reset clears all tap state and
// loads the window registers with their defaults.
module double_tap_gesture_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtgd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtgd_pkg::CfgDataW-1:0] cfg_wdata_i,
  dtgd_frame_if.sink                    in_if,
  dtgd_result_if.source                 out_if
);

  localparam int unsigned IdW   = dtgd_pkg::IdW;
  localparam int unsigned LenW  = dtgd_pkg::LenW;
  localparam int unsigned ByteW = dtgd_pkg::ByteW;
  localparam int unsigned TimeW = dtgd_pkg::TimeW;
  localparam int unsigned DurW  = dtgd_pkg::DurW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [IdW-1:0]  match_id_q;
  logic [DurW-1:0] press_min_q, press_max_q, gap_min_q, gap_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q  <= dtgd_pkg::MatchIdRst;
      press_min_q <= dtgd_pkg::PressMinRst;
      press_max_q <= dtgd_pkg::PressMaxRst;
      gap_min_q   <= dtgd_pkg::GapMinRst;
      gap_max_q   <= dtgd_pkg::GapMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtgd_pkg::CFG_MATCH_ID:  match_id_q  <= cfg_wdata_i[IdW-1:0];
        dtgd_pkg::CFG_PRESS_MIN: press_min_q <= cfg_wdata_i[DurW-1:0];
        dtgd_pkg::CFG_PRESS_MAX: press_max_q <= cfg_wdata_i[DurW-1:0];
        dtgd_pkg::CFG_GAP_MIN:   gap_min_q   <= cfg_wdata_i[DurW-1:0];
        dtgd_pkg::CFG_GAP_MAX:   gap_max_q   <= cfg_wdata_i[DurW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register feeds output register
  // ---------------------------------------------------------------------
  logic in_valid_q, out_valid_q;
  logic out_free, s1_fire, in_fire;

  assign out_free     = !out_valid_q || out_if.ready;
  assign s1_fire      = in_valid_q && out_free;
  assign in_if.ready  = !in_valid_q || out_free;
  assign in_fire      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register: payload only
  logic [IdW-1:0]   id_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] status_q, button_q;
  logic [TimeW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q     <= in_if.frame_id;
      len_q    <= in_if.frame_len;
      status_q <= in_if.status_byte;
      button_q <= in_if.button_byte;
      now_q    <= in_if.now_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Tap state
  // ---------------------------------------------------------------------
  logic              seen_q, seen_d;
  logic [TimeW-1:0]  prev_time_q, prev_time_d;
  logic [TimeW-1:0]  min_gap_q, min_gap_d;
  logic              drv_bit_q, drv_bit_d;
  logic [TimeW-1:0]  drv_stamp_q, drv_stamp_d;
  logic              drv_valid_q, drv_valid_d;
  logic              held_q, held_d;
  logic [TimeW-1:0]  rise_time_q, rise_time_d;
  logic [ByteW-1:0]  rise_cap_q, rise_cap_d;
  logic [DurW-1:0]   press_q, press_d;
  logic [DurW-1:0]   gap_q, gap_d;
  dtgd_pkg::reject_e reject_q, reject_d;
  logic              banked_q, banked_d;
  logic [TimeW-1:0]  first_rel_q, first_rel_d;
  logic [DurW-1:0]   count_q, count_d;
  logic [TimeW-1:0]  ges_stamp_q, ges_stamp_d;
  logic              gesture_d;

  logic              accept;
  logic              up, auto_up;
  logic [TimeW-1:0]  frame_gap;
  logic [DurW-1:0]   press_len, gap_len;

  assign accept    = (id_q == match_id_q) && len_q[LenW-1] && (status_q[1:0] == 2'b00);
  assign up        = button_q[0];
  assign auto_up   = button_q[1];
  assign frame_gap = now_q - prev_time_q;
  assign press_len = dtgd_pkg::sat_dur(now_q - rise_time_q);
  assign gap_len   = dtgd_pkg::sat_dur(rise_time_q - first_rel_q);

  always_comb begin
    seen_d      = seen_q;
    prev_time_d = prev_time_q;
    min_gap_d   = min_gap_q;
    drv_bit_d   = drv_bit_q;
    drv_stamp_d = drv_stamp_q;
    drv_valid_d = drv_valid_q;
    held_d      = held_q;
    rise_time_d = rise_time_q;
    rise_cap_d  = rise_cap_q;
    press_d     = press_q;
    gap_d       = gap_q;
    reject_d    = reject_q;
    banked_d    = banked_q;
    first_rel_d = first_rel_q;
    count_d     = count_q;
    ges_stamp_d = ges_stamp_q;
    gesture_d   = 1'b0;

    if (accept) begin
      // Track the smallest nonzero gap between accepted frames
      if (seen_q && (frame_gap != '0) && ((min_gap_q == '0) || (frame_gap < min_gap_q))) begin
        min_gap_d = frame_gap;
      end
      prev_time_d = now_q;
      seen_d      = 1'b1;
      drv_bit_d   = status_q[4];
      drv_stamp_d = now_q;
      drv_valid_d = 1'b1;

      if (up && !held_q) begin
        // Rising edge: start timing the press, leave the reject code alone
        held_d      = 1'b1;
        rise_time_d = now_q;
        rise_cap_d  = button_q;
      end else if (!up && held_q) begin
        // Falling edge: check the press, then the gap to the banked tap
        held_d  = 1'b0;
        press_d = press_len;
        if (auto_up) begin
          reject_d = dtgd_pkg::REJ_AUTO;
          banked_d = 1'b0;
        end else if (press_len < press_min_q) begin
          reject_d = dtgd_pkg::REJ_PSHORT;
          banked_d = 1'b0;
        end else if (press_len > press_max_q) begin
          reject_d = dtgd_pkg::REJ_PLONG;
          banked_d = 1'b0;
        end else if (!banked_q) begin
          banked_d    = 1'b1;
          first_rel_d = now_q;
          reject_d    = dtgd_pkg::REJ_NONE;
        end else begin
          gap_d = gap_len;
          if (gap_len < gap_min_q) begin
            reject_d    = dtgd_pkg::REJ_GSHORT;
            first_rel_d = now_q;
          end else if (gap_len > gap_max_q) begin
            reject_d    = dtgd_pkg::REJ_GLONG;
            first_rel_d = now_q;
          end else begin
            banked_d    = 1'b0;
            reject_d    = dtgd_pkg::REJ_NONE;
            count_d     = count_q + 16'd1;
            ges_stamp_d = now_q;
            gesture_d   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      prev_time_q <= '0;
      min_gap_q   <= '0;
      drv_bit_q   <= 1'b0;
      drv_stamp_q <= '0;
      drv_valid_q <= 1'b0;
      held_q      <= 1'b0;
      rise_time_q <= '0;
      rise_cap_q  <= '0;
      press_q     <= '0;
      gap_q       <= '0;
      reject_q    <= dtgd_pkg::REJ_NONE;
      banked_q    <= 1'b0;
      first_rel_q <= '0;
      count_q     <= '0;
      ges_stamp_q <= '0;
    end else if (s1_fire) begin
      seen_q      <= seen_d;
      prev_time_q <= prev_time_d;
      min_gap_q   <= min_gap_d;
      drv_bit_q   <= drv_bit_d;
      drv_stamp_q <= drv_stamp_d;
      drv_valid_q <= drv_valid_d;
      held_q      <= held_d;
      rise_time_q <= rise_time_d;
      rise_cap_q  <= rise_cap_d;
      press_q     <= press_d;
      gap_q       <= gap_d;
      reject_q    <= reject_d;
      banked_q    <= banked_d;
      first_rel_q <= first_rel_d;
      count_q     <= count_d;
      ges_stamp_q <= ges_stamp_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: state after the frame
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_if.gesture       <= gesture_d;
      out_if.accepted      <= accept;
      out_if.tap_count     <= count_d;
      out_if.reject_code   <= reject_d;
      out_if.press_length  <= press_d;
      out_if.gap_length    <= gap_d;
      out_if.min_frame_gap <= min_gap_d;
      out_if.driver_here   <= drv_bit_d;
      out_if.driver_known  <= drv_valid_d;
      out_if.driver_time   <= drv_stamp_d;
      out_if.rise_byte     <= rise_cap_d;
      out_if.gesture_time  <= ges_stamp_d;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for double_tap_gesture_detector: directed frames, then random tap
// sequences under several window settings. Depends on dtgd_pkg, dtgd_if and the RTL top.
module tb_top;

  localparam int unsigned IdW      = dtgd_pkg::IdW;
  localparam int unsigned LenW     = dtgd_pkg::LenW;
  localparam int unsigned ByteW    = dtgd_pkg::ByteW;
  localparam int unsigned TimeW    = dtgd_pkg::TimeW;
  localparam int unsigned DurW     = dtgd_pkg::DurW;
  localparam int unsigned CfgIdxW  = dtgd_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = dtgd_pkg::CfgDataW;

  localparam int NumScript  = 26;
  localparam int PhaseBeats = 180;     // well-formed frame beats per random phase
  localparam int NumPhases  = 6;
  localparam int LongHold   = 300;     // receiver hold-off, in cycles
  localparam int CycleLimit = 200000;
  localparam int PrintLimit = 40;

  // One received bus frame
  typedef struct {
    logic [IdW-1:0]   frame_id;
    logic [LenW-1:0]  frame_len;
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] button_byte;
    logic [TimeW-1:0] now_ms;
  } frame_t;

  // One status result, field for field as on the result channel
  typedef struct {
    logic              gesture;
    logic              accepted;
    logic [DurW-1:0]   tap_count;
    dtgd_pkg::reject_e reject_code;
    logic [DurW-1:0]   press_length;
    logic [DurW-1:0]   gap_length;
    logic [TimeW-1:0]  min_frame_gap;
    logic              driver_here;
    logic              driver_known;
    logic [TimeW-1:0]  driver_time;
    logic [ByteW-1:0]  rise_byte;
    logic [TimeW-1:0]  gesture_time;
  } status_t;

  // Fields typed in by hand for a directed beat; they replace the tracker's values
  typedef struct {
    bit                typed;
    logic              acc;
    dtgd_pkg::reject_e rej;
    logic [DurW-1:0]   cnt;
  } pin_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  status;
    logic [ByteW-1:0]  buttons;
    logic [TimeW-1:0]  stamp;
    logic              typed;
    logic              acc;
    dtgd_pkg::reject_e rej;
    logic [DurW-1:0]   cnt;
  } script_row_t;

  // Tap tracker state, a mirror of what the block keeps
  typedef struct {
    logic             seen;
    logic [TimeW-1:0] prev_time;
    logic [TimeW-1:0] min_gap;
    logic             drv_bit;
    logic [TimeW-1:0] drv_stamp;
    logic             drv_valid;
    logic             held;
    logic [TimeW-1:0] rise_time;
    logic [ByteW-1:0] rise_byte;
    logic [DurW-1:0]  press;
    logic [DurW-1:0]  gap;
    logic [2:0]       reject;
    logic             banked;
    logic [TimeW-1:0] first_release;
    logic [DurW-1:0]  count;
    logic [TimeW-1:0] gesture_stamp;
  } tap_track_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  dtgd_frame_if  frame_ch ();
  dtgd_result_if status_ch ();

  double_tap_gesture_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (frame_ch),
    .out_if      (status_ch)
  );

  always #4 clk_i = ~clk_i;

  // Window settings as last written, and the tracker that uses them
  logic [IdW-1:0]  win_match_id  = dtgd_pkg::MatchIdRst;
  logic [DurW-1:0] win_press_min = dtgd_pkg::PressMinRst;
  logic [DurW-1:0] win_press_max = dtgd_pkg::PressMaxRst;
  logic [DurW-1:0] win_gap_min   = dtgd_pkg::GapMinRst;
  logic [DurW-1:0] win_gap_max   = dtgd_pkg::GapMaxRst;
  tap_track_t      trk;

  status_t status_due [$];   // results owed by the block, oldest first
  pin_t    pinned_q [$];     // hand-typed fields, one entry per driven beat
  frame_t  frame_plan [$];   // frames of the current random phase

  int mismatch_count = 0;
  int result_beats   = 0;
  int cycle_count    = 0;
  int send_calm      = 0;
  int sink_calm      = 0;
  bit hold_off_req   = 1'b0;

  // Directed frames under the reset windows (id 0, press 40..500, gap 120..900).
  // Typed rows carry accepted, reject code and count as read off by hand.
  script_row_t script [NumScript] = '{
    // not accepted: short length, wrong identifier, mux 1, mux 2
    '{29'h0, 4'd7, 8'h00, 8'h00, 32'd1000, 1'b1, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h5, 4'd8, 8'h00, 8'h00, 32'd1000, 1'b1, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h01, 8'h00, 32'd1000, 1'b1, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h02, 8'h00, 32'd1000, 1'b1, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    // first accepted frame, then the same timestamp again
    '{29'h0, 4'd15, 8'h10, 8'h00, 32'd1000, 1'b1, 1'b1, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd1000, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    // clean double tap: press 100, gap 300, press 100
    '{29'h0, 4'd8, 8'h10, 8'h01, 32'd1100, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h10, 8'h00, 32'd1200, 1'b1, 1'b1, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h10, 8'h01, 32'd1500, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h10, 8'h00, 32'd1600, 1'b1, 1'b1, dtgd_pkg::REJ_NONE, 16'd1},
    // press too short, press too long, auto-up at release
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd2000, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd2010, 1'b1, 1'b1, dtgd_pkg::REJ_PSHORT, 16'd1},
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd3000, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd3600, 1'b1, 1'b1, dtgd_pkg::REJ_PLONG, 16'd1},
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd4000, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h02, 32'd4100, 1'b1, 1'b1, dtgd_pkg::REJ_AUTO, 16'd1},
    // bank a tap, then a gap too short; the second tap becomes the first
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd5000, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd5100, 1'b1, 1'b1, dtgd_pkg::REJ_NONE, 16'd1},
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd5150, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd5250, 1'b1, 1'b1, dtgd_pkg::REJ_GSHORT, 16'd1},
    // rising edge keeps the old reject code; then a gap too long
    '{29'h0, 4'd8, 8'h00, 8'h01, 32'd7000, 1'b1, 1'b1, dtgd_pkg::REJ_GSHORT, 16'd1},
    '{29'h0, 4'd8, 8'h00, 8'h00, 32'd7100, 1'b1, 1'b1, dtgd_pkg::REJ_GLONG, 16'd1},
    // press across the timestamp wrap saturates the duration
    '{29'h0, 4'd8, 8'h00, 8'hFD, 32'hFFFF_FFFF, 1'b0, 1'b0, dtgd_pkg::REJ_NONE, 16'd0},
    '{29'h0, 4'd8, 8'hEC, 8'hFC, 32'h0002_0000, 1'b1, 1'b1, dtgd_pkg::REJ_PLONG, 16'd1},
    // all-ones frame and mux 3 leave the state alone
    '{29'h1FFF_FFFF, 4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
      dtgd_pkg::REJ_PLONG, 16'd1},
    '{29'h0, 4'd8, 8'h03, 8'h00, 32'd0, 1'b1, 1'b0, dtgd_pkg::REJ_PLONG, 16'd1}
  };

  function automatic logic [DurW-1:0] clip_ms(input logic [TimeW-1:0] span);
    return (span > 32'h0000_FFFF) ? 16'hFFFF : span[DurW-1:0];
  endfunction

  // Advance the tap tracker by one frame and return the status it leaves behind
  function automatic status_t track_frame(input frame_t f);
    status_t          s;
    logic             up_btn, auto_btn, hit, done;
    logic [TimeW-1:0] step;
    up_btn   = f.button_byte[0];
    auto_btn = f.button_byte[1];
    hit  = (f.frame_id == win_match_id) && (f.frame_len >= 4'd8)
           && (f.status_byte[1:0] == 2'b00);
    done = 1'b0;
    if (hit) begin
      // smallest nonzero spacing of accepted frames, modulo 2^32
      if (trk.seen) begin
        step = f.now_ms - trk.prev_time;
        if (step != '0 && (trk.min_gap == '0 || step < trk.min_gap)) trk.min_gap = step;
      end
      trk.prev_time = f.now_ms;
      trk.seen      = 1'b1;
      trk.drv_bit   = f.status_byte[4];
      trk.drv_stamp = f.now_ms;
      trk.drv_valid = 1'b1;
      if (up_btn && !trk.held) begin
        trk.held      = 1'b1;
        trk.rise_time = f.now_ms;
        trk.rise_byte = f.button_byte;
      end else if (!up_btn && trk.held) begin
        trk.held  = 1'b0;
        trk.press = clip_ms(f.now_ms - trk.rise_time);
        // first failing check wins, even with inverted windows
        if (auto_btn) begin
          trk.reject = dtgd_pkg::REJ_AUTO;
          trk.banked = 1'b0;
        end else if (trk.press < win_press_min) begin
          trk.reject = dtgd_pkg::REJ_PSHORT;
          trk.banked = 1'b0;
        end else if (trk.press > win_press_max) begin
          trk.reject = dtgd_pkg::REJ_PLONG;
          trk.banked = 1'b0;
        end else if (!trk.banked) begin
          trk.banked        = 1'b1;
          trk.first_release = f.now_ms;
          trk.reject        = dtgd_pkg::REJ_NONE;
        end else begin
          trk.gap = clip_ms(trk.rise_time - trk.first_release);
          if (trk.gap < win_gap_min) begin
            trk.reject        = dtgd_pkg::REJ_GSHORT;
            trk.first_release = f.now_ms;
          end else if (trk.gap > win_gap_max) begin
            trk.reject        = dtgd_pkg::REJ_GLONG;
            trk.first_release = f.now_ms;
          end else begin
            trk.banked        = 1'b0;
            trk.reject        = dtgd_pkg::REJ_NONE;
            trk.count         = trk.count + 16'd1;
            trk.gesture_stamp = f.now_ms;
            done              = 1'b1;
          end
        end
      end
    end
    s.gesture       = done;
    s.accepted      = hit;
    s.tap_count     = trk.count;
    s.reject_code   = dtgd_pkg::reject_e'(trk.reject);
    s.press_length  = trk.press;
    s.gap_length    = trk.gap;
    s.min_frame_gap = trk.min_gap;
    s.driver_here   = trk.drv_bit;
    s.driver_known  = trk.drv_valid;
    s.driver_time   = trk.drv_stamp;
    s.rise_byte     = trk.rise_byte;
    s.gesture_time  = trk.gesture_stamp;
    return s;
  endfunction

  // Idle cycles before the next beat, drawn at random, with calm runs of none at all
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Duration aimed at a window: its edges, one past them, inside, or far out
  function automatic int unsigned pick_span(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 9))
      0: return (lo > 0) ? lo - 1 : 0;
      1: return lo;
      2: return hi;
      3: return hi + 1;
      4: return $urandom_range(0, 70000);
      default: return (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic frame_t good_frame(input logic [ByteW-1:0] btn, input logic [TimeW-1:0] t);
    frame_t f;
    f.frame_id    = win_match_id;
    f.frame_len   = LenW'($urandom_range(8, 15));
    f.status_byte = {6'($urandom), 2'b00};
    f.button_byte = btn;
    f.now_ms      = t;
    return f;
  endfunction

  // Frame the filter must drop: wrong id, short length or nonzero mux
  function automatic frame_t stray_frame();
    frame_t f;
    f = good_frame(8'($urandom), $urandom);
    case ($urandom_range(0, 2))
      0: begin
        f.frame_id = IdW'($urandom);
        if (f.frame_id == win_match_id) f.frame_id = ~f.frame_id;
      end
      1: f.frame_len = LenW'($urandom_range(0, 7));
      default: f.status_byte[1:0] = 2'($urandom_range(1, 3));
    endcase
    return f;
  endfunction

  // Build a phase of tap sequences: optional idle frames in the gap, a press,
  // an optional hold frame, a release; strays sprinkled in between
  task automatic plan_phase(input int unsigned beats_wanted, input logic [TimeW-1:0] t0);
    int unsigned      good_beats, span_gap, span_press;
    logic [TimeW-1:0] t, rise;
    frame_plan.delete();
    good_beats = 0;
    t = t0;
    while (good_beats < beats_wanted) begin
      if ($urandom_range(0, 7) == 0) frame_plan.push_back(stray_frame());
      span_gap = pick_span(win_gap_min, win_gap_max);
      if ($urandom_range(0, 29) == 0) span_gap = $urandom;   // long silence
      rise = t + span_gap;
      if ($urandom_range(0, 2) == 0) begin
        frame_plan.push_back(good_frame(8'($urandom) & 8'hFE, t + span_gap / 2));
        good_beats++;
        // repeat the timestamp now and then: a zero spacing
        if ($urandom_range(0, 3) == 0) begin
          frame_plan.push_back(good_frame(8'($urandom) & 8'hFE, t + span_gap / 2));
          good_beats++;
        end
      end
      frame_plan.push_back(good_frame(8'($urandom) | 8'h01, rise));
      span_press = pick_span(win_press_min, win_press_max);
      if ($urandom_range(0, 3) == 0) begin
        frame_plan.push_back(good_frame(8'($urandom) | 8'h01, rise + span_press / 2));
        good_beats++;
      end
      t = rise + span_press;
      frame_plan.push_back(good_frame({6'($urandom), ($urandom_range(0, 9) == 0), 1'b0}, t));
      good_beats += 2;
    end
  endtask

  // Offer one frame beat and hold it until the block takes it
  task automatic send_frame(input frame_t f, input pin_t pin);
    int pause;
    pause = draw_pause(send_calm);
    if (pause > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    pinned_q.push_back(pin);
    frame_ch.valid       <= 1'b1;
    frame_ch.frame_id    <= f.frame_id;
    frame_ch.frame_len   <= f.frame_len;
    frame_ch.status_byte <= f.status_byte;
    frame_ch.button_byte <= f.button_byte;
    frame_ch.now_ms      <= f.now_ms;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
  endtask

  // Write all five registers back to back; the block is idle here
  task automatic program_windows(input logic [IdW-1:0] id, input logic [DurW-1:0] pmin,
                                 input logic [DurW-1:0] pmax, input logic [DurW-1:0] gmin,
                                 input logic [DurW-1:0] gmax);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= dtgd_pkg::CFG_MATCH_ID;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_idx_i   <= dtgd_pkg::CFG_PRESS_MIN;
    cfg_wdata_i <= CfgDataW'(pmin);
    @(posedge clk_i);
    cfg_idx_i   <= dtgd_pkg::CFG_PRESS_MAX;
    cfg_wdata_i <= CfgDataW'(pmax);
    @(posedge clk_i);
    cfg_idx_i   <= dtgd_pkg::CFG_GAP_MIN;
    cfg_wdata_i <= CfgDataW'(gmin);
    @(posedge clk_i);
    cfg_idx_i   <= dtgd_pkg::CFG_GAP_MAX;
    cfg_wdata_i <= CfgDataW'(gmax);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_match_id  = id;
    win_press_min = pmin;
    win_press_max = pmax;
    win_gap_min   = gmin;
    win_gap_max   = gmax;
  endtask

  // Hold until every owed result has come back
  task automatic wait_drained();
    do @(posedge clk_i); while (status_due.size() != 0);
  endtask

  task automatic note_mismatch(input string what);
    if (mismatch_count < PrintLimit) begin
      $display("[%0t] result beat %0d: %s", $realtime, result_beats, what);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Frame beat taken: advance the tracker, apply any typed fields, owe a result
  frame_t  taken_frame;
  status_t fresh_status;
  pin_t    taken_pin;
  always @(posedge clk_i) begin
    if (rst_ni && frame_ch.valid && frame_ch.ready) begin
      taken_frame.frame_id    = frame_ch.frame_id;
      taken_frame.frame_len   = frame_ch.frame_len;
      taken_frame.status_byte = frame_ch.status_byte;
      taken_frame.button_byte = frame_ch.button_byte;
      taken_frame.now_ms      = frame_ch.now_ms;
      fresh_status = track_frame(taken_frame);
      taken_pin    = pinned_q.pop_front();
      if (taken_pin.typed) begin
        fresh_status.accepted    = taken_pin.acc;
        fresh_status.reject_code = taken_pin.rej;
        fresh_status.tap_count   = taken_pin.cnt;
      end
      status_due.push_back(fresh_status);
    end
  end

  // Result beat taken: compare it with the oldest owed result
  status_t want;
  always @(posedge clk_i) begin
    if (rst_ni && status_ch.valid && status_ch.ready) begin
      if (status_due.size() == 0) begin
        note_mismatch("result with nothing owed");
      end else begin
        want = status_due.pop_front();
        check_field("gesture", status_ch.gesture, want.gesture);
        check_field("accepted", status_ch.accepted, want.accepted);
        check_field("tap_count", status_ch.tap_count, want.tap_count);
        check_field("reject_code", status_ch.reject_code, want.reject_code);
        check_field("press_length", status_ch.press_length, want.press_length);
        check_field("gap_length", status_ch.gap_length, want.gap_length);
        check_field("min_frame_gap", status_ch.min_frame_gap, want.min_frame_gap);
        check_field("driver_here", status_ch.driver_here, want.driver_here);
        check_field("driver_known", status_ch.driver_known, want.driver_known);
        check_field("driver_time", status_ch.driver_time, want.driver_time);
        check_field("rise_byte", status_ch.rise_byte, want.rise_byte);
        check_field("gesture_time", status_ch.gesture_time, want.gesture_time);
      end
      result_beats++;
    end
  end

  // Receiver: random stalls per beat, plus one long hold-off on request so
  // the block fills up and drops in_if.ready while frames keep coming
  initial begin : result_sink
    int pause;
    bit hold_done;
    hold_done = 1'b0;
    status_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pause = draw_pause(sink_calm);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        pause = pause + LongHold;
      end
      if (pause > 0) begin
        status_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      status_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!status_ch.valid) @(posedge clk_i);
    end
  end

  // Watchdog: drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    pin_t            pin;
    frame_t          f;
    logic [IdW-1:0]  id;
    logic [DurW-1:0] pmin, pmax, gmin, gmax;
    logic [TimeW-1:0] t0;

    // Drive every input to a known value before the first edge
    frame_ch.valid       <= 1'b0;
    frame_ch.frame_id    <= '0;
    frame_ch.frame_len   <= '0;
    frame_ch.status_byte <= '0;
    frame_ch.button_byte <= '0;
    frame_ch.now_ms      <= '0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= dtgd_pkg::CFG_MATCH_ID;
    cfg_wdata_i          <= '0;
    trk = '{default: '0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset windows
    for (int i = 0; i < NumScript; i++) begin
      f.frame_id    = script[i].id;
      f.frame_len   = script[i].len;
      f.status_byte = script[i].status;
      f.button_byte = script[i].buttons;
      f.now_ms      = script[i].stamp;
      pin.typed = script[i].typed;
      pin.acc   = script[i].acc;
      pin.rej   = script[i].rej;
      pin.cnt   = script[i].cnt;
      send_frame(f, pin);
    end
    frame_ch.valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own window setting
    pin = '{typed: 1'b0, acc: 1'b0, rej: dtgd_pkg::REJ_NONE, cnt: '0};
    for (int phase = 1; phase <= NumPhases; phase++) begin
      id   = IdW'($urandom);
      pmin = DurW'($urandom_range(0, 200));
      pmax = pmin + DurW'($urandom_range(50, 800));
      gmin = DurW'($urandom_range(0, 300));
      gmax = gmin + DurW'($urandom_range(100, 1500));
      t0   = $urandom;
      case (phase)
        1: begin   // widest windows, all-ones identifier
          id = '1; pmin = '0; pmax = '1; gmin = '0; gmax = '1;
        end
        2: begin   // narrowest: every window pinned at the top
          id = '0; pmin = '1; pmax = '1; gmin = '1; gmax = '1;
        end
        4: begin   // inverted windows, timestamps about to wrap
          pmin = 16'd600; pmax = 16'd100; gmin = 16'd900; gmax = 16'd120;
          t0 = 32'hFFFF_F000;
        end
        default: ;
      endcase
      program_windows(id, pmin, pmax, gmin, gmax);
      if (phase == 3) hold_off_req = 1'b1;
      plan_phase(PhaseBeats, t0);
      foreach (frame_plan[k]) send_frame(frame_plan[k], pin);
      frame_ch.valid <= 1'b0;
      wait_drained();
    end

    // Let the pipeline settle, then judge
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) note_mismatch("results still owed at end of run");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
